>>> hdl/lr_pkg.sv
// Shared types for the line rasterizer: controller states and the command
// and status groups that join the controller to the datapath.
// No dependencies.
package lr_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } lr_state_type;

   typedef struct packed {
      logic capture;
      logic setup;
      logic emit;
   } lr_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last;
   } lr_status_type;

endpackage

>>> hdl/lr_ctrl.sv
// Controller state machine of the line rasterizer.
// Depends on lr_pkg for the state, command and status types.
module lr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  lr_pkg::lr_status_type status,
   output lr_pkg::lr_cmd_type    cmd
);
   import lr_pkg::*;

   lr_state_type state_ff;
   lr_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.out_free && status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.setup   = 1'b0;
      cmd.emit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_RUN: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("pixel loaded while the output slot was still occupied");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.last) |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after the final pixel");

   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SETUP))
      else $error("accepted request not followed by set-up");
`endif

endmodule

>>> hdl/lr_dpath.sv
// Datapath of the line rasterizer: request capture, octant set-up, the
// error-term stepper and the output register. Depends on lr_pkg.
module lr_dpath #(
   parameter int COORD_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COORD_BITS-1:0] x_start,
   input  logic [COORD_BITS-1:0] y_start,
   input  logic [COORD_BITS-1:0] x_end,
   input  logic [COORD_BITS-1:0] y_end,
   input  lr_pkg::lr_cmd_type    cmd,
   output lr_pkg::lr_status_type status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [COORD_BITS-1:0] point_x,
   output logic [COORD_BITS-1:0] point_y,
   output logic                  last_point
);
   import lr_pkg::*;

   localparam int C = COORD_BITS;
   localparam int E = COORD_BITS + 3;
   localparam int S = COORD_BITS + 1;

   logic [C-1:0] xa_ff, ya_ff, xb_ff, yb_ff;
   logic [C-1:0] xa_in, ya_in, xb_in, yb_in;
   logic [C-1:0] major_ff, major_in, minor_ff, minor_in;
   logic [E-1:0] err_ff, err_in, step_ax_ff, step_ax_in, step_dg_ff, step_dg_in;
   logic [S-1:0] steps_ff, steps_in;
   logic         steep_ff, steep_in, falling_ff, falling_in;
   logic [C-1:0] px_ff, px_in, py_ff, py_in;
   logic         last_ff, last_in, valid_ff, valid_in;

   logic         swap, falling, steep;
   logic [C-1:0] ax, ay, bx, by, dx, dy, dmaj, dmin;
   logic [E-1:0] dmaj_e, dmin_e;

   always_comb begin
      swap    = xb_ff < xa_ff;
      ax      = swap ? xb_ff : xa_ff;
      ay      = swap ? yb_ff : ya_ff;
      bx      = swap ? xa_ff : xb_ff;
      by      = swap ? ya_ff : yb_ff;
      falling = by < ay;
      dx      = bx - ax;
      dy      = falling ? (ay - by) : (by - ay);
      steep   = dx < dy;
      dmaj    = steep ? dy : dx;
      dmin    = steep ? dx : dy;
      dmaj_e  = E'(dmaj);
      dmin_e  = E'(dmin);
   end

   always_comb begin
      xa_in      = xa_ff;
      ya_in      = ya_ff;
      xb_in      = xb_ff;
      yb_in      = yb_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      err_in     = err_ff;
      step_ax_in = step_ax_ff;
      step_dg_in = step_dg_ff;
      steps_in   = steps_ff;
      steep_in   = steep_ff;
      falling_in = falling_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      last_in    = last_ff;
      valid_in   = valid_ff;

      if (rsp_tready) begin
         valid_in = 1'b0;
      end

      if (cmd.capture) begin
         xa_in = x_start;
         ya_in = y_start;
         xb_in = x_end;
         yb_in = y_end;
      end

      if (cmd.setup) begin
         steep_in   = steep;
         falling_in = falling;
         major_in   = steep ? ay : ax;
         minor_in   = steep ? ax : ay;
         err_in     = (dmin_e << 1) - dmaj_e;
         step_ax_in = dmin_e << 1;
         step_dg_in = (dmin_e - dmaj_e) << 1;
         steps_in   = S'(dmaj) + S'(1);
      end

      if (cmd.emit) begin
         valid_in = 1'b1;
         px_in    = steep_ff ? minor_ff : major_ff;
         py_in    = steep_ff ? major_ff : minor_ff;
         last_in  = steps_ff == S'(1);
         steps_in = steps_ff - S'(1);
         major_in = (steep_ff && falling_ff) ? (major_ff - C'(1)) : (major_ff + C'(1));
         if (err_ff[E-1]) begin
            err_in = err_ff + step_ax_ff;
         end else begin
            err_in   = err_ff + step_dg_ff;
            minor_in = (!steep_ff && falling_ff) ? (minor_ff - C'(1))
                                                 : (minor_ff + C'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xa_ff      <= xa_in;
      ya_ff      <= ya_in;
      xb_ff      <= xb_in;
      yb_ff      <= yb_in;
      major_ff   <= major_in;
      minor_ff   <= minor_in;
      err_ff     <= err_in;
      step_ax_ff <= step_ax_in;
      step_dg_ff <= step_dg_in;
      steps_ff   <= steps_in;
      steep_ff   <= steep_in;
      falling_ff <= falling_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      last_ff    <= last_in;
   end

   assign status.out_free = !valid_ff || rsp_tready;
   assign status.last     = steps_ff == S'(1);
   assign rsp_tvalid      = valid_ff;
   assign point_x         = px_ff;
   assign point_y         = py_ff;
   assign last_point      = last_ff;

endmodule

>>> hdl/line_rasterizer.sv
// Top level of the line rasterizer: stream ports, field packing, and the
// controller and datapath. Depends on lr_pkg, lr_ctrl and lr_dpath.
//
// Usage: one request beat on the req_ channel carries two endpoints. The
// block answers with the pixels of the Bresenham line between them on the
// rsp_ channel, one beat per pixel, ordered from the endpoint of smaller x,
// with rsp_tlast high on the final pixel. Equal endpoints give one beat.
// After a request beat is accepted, the endpoints are captured, the octant
// set-up runs, and the first pixel is loaded into the output register. A
// line of n pixels then streams at one pixel per cycle while the receiver
// keeps rsp_tready high, and the next request is accepted in the cycle
// after the final pixel is loaded; a line has up to 2^COORD_BITS pixels.
// The rate is set by the single error-term stepper.
// When the receiver stalls, the pending pixel holds in the output register
// and stepping pauses; no beat is lost or repeated. Synchronous reset
// returns the controller to idle and drops rsp_tvalid.
module line_rasterizer #(
   parameter  int COORD_BITS = 6,
   localparam int ReqBits    = ((4 * COORD_BITS + 7) / 8) * 8,
   localparam int RspBits    = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [ReqBits-1:0] req_tdata,  // x_start, y_start, x_end, y_end
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RspBits-1:0] rsp_tdata,  // point_x, point_y
   output logic               rsp_tlast   // last_point
);
   import lr_pkg::*;

   localparam int C = COORD_BITS;

   lr_cmd_type    cmd;
   lr_status_type status;
   logic [C-1:0]  point_x, point_y;

   lr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lr_dpath #(
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .x_start    (req_tdata[C-1:0]),
      .y_start    (req_tdata[2*C-1:C]),
      .x_end      (req_tdata[3*C-1:2*C]),
      .y_end      (req_tdata[4*C-1:3*C]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .point_x    (point_x),
      .point_y    (point_y),
      .last_point (rsp_tlast)
   );

   assign rsp_tdata = RspBits'({point_y, point_x});

endmodule

>>> tb/line_rasterizer_tb.sv
// Testbench for line_rasterizer: drives line requests on the req_ stream and
// checks every pixel beat on the rsp_ stream against a Bresenham predictor.
// Depends only on the line_rasterizer RTL.
module line_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CoordBits  = 6;
   localparam int CycleLimit = 1500000;

   typedef logic [CoordBits-1:0] coord_t;

   // Packed so that x_start lands in the lowest bits, as on req_tdata.
   typedef struct packed {
      coord_t y_end;
      coord_t x_end;
      coord_t y_start;
      coord_t x_start;
   } line_t;

   typedef struct packed {
      coord_t x;
      coord_t y;
      logic   last;
   } pixel_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;  // x_start, y_start, x_end, y_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // point_x, point_y
   logic        rsp_tlast;        // last_point

   pixel_t expected_pixels[$];
   int     mismatch_count = 0;
   int     cycle_count    = 0;
   bit     idle_enable    = 1'b1;

   line_rasterizer #(.COORD_BITS(CoordBits)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic trace_line(input line_t ln);
      int     xa, ya, xb, yb, tmp;
      int     dx, dy, dmaj, dmin, err, maj, mnr, maj_inc, mnr_inc, left;
      bit     steep, falling;
      pixel_t pix;
      begin
         xa = ln.x_start;
         ya = ln.y_start;
         xb = ln.x_end;
         yb = ln.y_end;
         if (xb < xa) begin
            tmp = xa; xa = xb; xb = tmp;
            tmp = ya; ya = yb; yb = tmp;
         end
         falling = yb < ya;
         dx      = xb - xa;
         dy      = falling ? ya - yb : yb - ya;
         steep   = dx < dy;
         if (steep) begin
            dmaj = dy; dmin = dx; maj = ya; mnr = xa;
            maj_inc = falling ? -1 : 1;
            mnr_inc = 1;
         end else begin
            dmaj = dx; dmin = dy; maj = xa; mnr = ya;
            maj_inc = 1;
            mnr_inc = falling ? -1 : 1;
         end
         err  = 2 * dmin - dmaj;
         left = dmaj + 1;
         while (left > 0) begin
            left--;
            pix.x    = coord_t'(steep ? mnr : maj);
            pix.y    = coord_t'(steep ? maj : mnr);
            pix.last = (left == 0);
            expected_pixels.push_back(pix);
            maj += maj_inc;
            if (err < 0) begin
               err += 2 * dmin;
            end else begin
               mnr += mnr_inc;
               err += 2 * (dmin - dmaj);
            end
         end
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance
   // with req_tvalid still high, so back-to-back requests need no toggle.
   task automatic send_line(input line_t ln);
      begin
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 24'($urandom);
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= ln;
         do @(posedge clock); while (!req_tready);
         trace_line(ln);
         @(negedge clock);
      end
   endtask

   function automatic line_t make_line(input int xs, ys, xe, ye);
      line_t ln;
      begin
         ln.x_start = coord_t'(xs);
         ln.y_start = coord_t'(ys);
         ln.x_end   = coord_t'(xe);
         ln.y_end   = coord_t'(ye);
         return ln;
      end
   endfunction

   function automatic int near_coord(input int c);
      int v;
      begin
         v = c + $urandom_range(0, 14) - 7;
         if (v < 0) v = 0;
         if (v > 63) v = 63;
         return v;
      end
   endfunction

   function automatic line_t random_line();
      int    xs, ys, d, pick;
      line_t ln;
      begin
         pick = $urandom_range(0, 9);
         xs   = $urandom_range(0, 63);
         ys   = $urandom_range(0, 63);
         if (pick < 4) begin
            ln = make_line(xs, ys, $urandom_range(0, 63), $urandom_range(0, 63));
         end else if (pick < 8) begin
            ln = make_line(xs, ys, near_coord(xs), near_coord(ys));
         end else if (pick == 8) begin
            d  = $urandom_range(0, 63);
            xs = $urandom_range(0, 63 - d);
            if ($urandom_range(0, 1)) begin
               ys = $urandom_range(0, 63 - d);
               ln = make_line(xs, ys, xs + d, ys + d);
            end else begin
               ys = $urandom_range(d, 63);
               ln = make_line(xs, ys, xs + d, ys - d);
            end
            if ($urandom_range(0, 1))
               ln = make_line(ln.x_end, ln.y_end, ln.x_start, ln.y_start);
         end else begin
            case ($urandom_range(0, 2))
               0: ln = make_line(xs, ys, $urandom_range(0, 63), ys);
               1: ln = make_line(xs, ys, xs, $urandom_range(0, 63));
               default: ln = make_line(xs, ys, xs, ys);
            endcase
         end
         return ln;
      end
   endfunction

   task automatic test_single_points();
      begin
         send_line(make_line(0, 0, 0, 0));
         send_line(make_line(63, 63, 63, 63));
         send_line(make_line(21, 42, 21, 42));
      end
   endtask

   task automatic test_octants();
      begin
         send_line(make_line(0, 0, 63, 20));
         send_line(make_line(0, 63, 63, 40));
         send_line(make_line(10, 0, 20, 63));
         send_line(make_line(5, 63, 9, 0));
         send_line(make_line(63, 10, 0, 50));
         send_line(make_line(40, 60, 30, 2));
         send_line(make_line(0, 30, 63, 30));
         send_line(make_line(63, 5, 0, 5));
         send_line(make_line(17, 0, 17, 63));
         send_line(make_line(17, 63, 17, 0));
      end
   endtask

   task automatic test_diagonals_and_ties();
      begin
         send_line(make_line(0, 0, 63, 63));
         send_line(make_line(0, 63, 63, 0));
         send_line(make_line(63, 0, 0, 63));
         send_line(make_line(63, 63, 0, 0));
         send_line(make_line(0, 0, 10, 11));
         send_line(make_line(0, 0, 11, 10));
         send_line(make_line(1, 0, 0, 1));
         send_line(make_line(0, 0, 63, 0));
      end
   endtask

   task automatic test_random_lines(input int count);
      begin
         repeat (count) send_line(random_line());
      end
   endtask

   task automatic test_back_to_back(input int count);
      begin
         idle_enable = 1'b0;
         repeat (count) send_line(random_line());
      end
   endtask

   initial begin
      @(negedge clock);
      forever begin
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected pixel beat: x=%0d y=%0d last=%0b",
                        rsp_tdata[5:0], rsp_tdata[11:6], rsp_tlast);
         end else if (rsp_tdata[5:0] !== expected_pixels[0].x ||
                      rsp_tdata[11:6] !== expected_pixels[0].y ||
                      rsp_tlast !== expected_pixels[0].last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                        expected_pixels[0].x, expected_pixels[0].y,
                        expected_pixels[0].last, rsp_tdata[5:0], rsp_tdata[11:6],
                        rsp_tlast);
            void'(expected_pixels.pop_front());
         end else begin
            void'(expected_pixels.pop_front());
         end
      end
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_single_points();
      test_octants();
      test_diagonals_and_ties();
      test_random_lines(370);
      test_back_to_back(60);
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
